@@ hdl/date_text_validator_unit_defines.svh @@
// Assertion macros used by the date text validator checker file
`ifndef DATE_TEXT_VALIDATOR_UNIT_DEFINES_SVH
`define DATE_TEXT_VALIDATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define DAV_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date text validator assertion failed");

// Next-cycle implication, disabled while in reset
`define DAV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("date text validator assertion failed");

// Next-cycle implication that also holds across reset
`define DAV_ASSERT_RST(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("date text validator assertion failed");

`endif

@@ hdl/dav_pkg.sv @@
// Package: constants and helper functions of the date text validator
package dav_pkg;

  localparam int unsigned YearW  = 16;
  localparam int unsigned FieldW = 8;

  localparam logic [7:0] DashCode = 8'd45;
  localparam logic [7:0] DigitLo  = 8'd48;
  localparam logic [7:0] DigitHi  = 8'd57;

  localparam logic [FieldW-1:0] MonthMin  = 8'd1;
  localparam logic [FieldW-1:0] MonthMax  = 8'd12;
  localparam logic [FieldW-1:0] MonthFeb  = 8'd2;
  localparam logic [FieldW-1:0] MonthApr  = 8'd4;
  localparam logic [FieldW-1:0] MonthJun  = 8'd6;
  localparam logic [FieldW-1:0] MonthSep  = 8'd9;
  localparam logic [FieldW-1:0] MonthNov  = 8'd11;
  localparam logic [FieldW-1:0] DayLong   = 8'd31;
  localparam logic [FieldW-1:0] DayShort  = 8'd30;
  localparam logic [FieldW-1:0] DayLeap   = 8'd29;
  localparam logic [FieldW-1:0] DayFeb    = 8'd28;
  localparam logic [FieldW-1:0] FieldSat  = 8'd255;

  localparam logic [1:0] DashMax   = 2'd3;
  localparam logic [1:0] DashYear  = 2'd0;
  localparam logic [1:0] DashMonth = 2'd1;
  localparam logic [1:0] DashDay   = 2'd2;

  // acc * 10 + d, wrapping at 16 bits
  function automatic logic [YearW-1:0] year_step(input logic [YearW-1:0] acc,
                                                 input logic [3:0] d);
    year_step = (acc << 3) + (acc << 1) + {{(YearW-4){1'b0}}, d};
  endfunction

  // acc * 10 + d, saturating at 255
  function automatic logic [FieldW-1:0] sat_step(input logic [FieldW-1:0] acc,
                                                 input logic [3:0] d);
    logic [11:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, d};
    sat_step = (v > 12'd255) ? FieldSat : v[FieldW-1:0];
  endfunction

  function automatic logic [FieldW-1:0] day_limit(input logic [1:0] year_lo,
                                                  input logic [FieldW-1:0] month);
    logic [FieldW-1:0] lim;
    if (month == MonthFeb) begin
      lim = (year_lo == 2'd0) ? DayLeap : DayFeb;
    end else if (month == MonthApr || month == MonthJun ||
                 month == MonthSep || month == MonthNov) begin
      lim = DayShort;
    end else begin
      lim = DayLong;
    end
    day_limit = lim;
  endfunction

endpackage

@@ hdl/date_text_validator_unit.sv @@
// Top level: character-serial year-month-day text validator
// Accepts one character per clock cycle while in_ready is high, with no gaps
// between texts. Each accepted character updates the year, month or day
// accumulator chosen by the dashes seen so far, through a shift-and-add
// multiply by ten; at the character flagged last_char the validity check
// runs on the updated values and the result is registered into the output
// register, while the next text can start immediately. in_ready drops only
// while a finished result is held and out_ready is low.
module date_text_validator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_date_ok,
  output logic [15:0] out_year_value,
  output logic [7:0]  out_month_value,
  output logic [7:0]  out_day_value
);

  logic [1:0]  dash_count_r, dash_count_nxt;
  logic        bad_char_r, bad_char_nxt;
  logic [15:0] year_acc_r, year_acc_nxt;
  logic [7:0]  month_acc_r, month_acc_nxt;
  logic [7:0]  day_acc_r, day_acc_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        date_ok_r;
  logic [15:0] year_r;
  logic [7:0]  month_r;
  logic [7:0]  day_r;

  logic        accept;
  logic        is_dash;
  logic        is_digit;
  logic [3:0]  digit;
  logic        ok;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_dash  = (in_char_code == dav_pkg::DashCode);
  assign is_digit = (in_char_code >= dav_pkg::DigitLo) && (in_char_code <= dav_pkg::DigitHi);
  assign digit    = in_char_code[3:0];

  always_comb begin
    dash_count_nxt = dash_count_r;
    bad_char_nxt   = bad_char_r;
    year_acc_nxt   = year_acc_r;
    month_acc_nxt  = month_acc_r;
    day_acc_nxt    = day_acc_r;
    if (is_dash) begin
      if (dash_count_r != dav_pkg::DashMax) begin
        dash_count_nxt = dash_count_r + 2'd1;
      end
    end else if (is_digit) begin
      case (dash_count_r)
        dav_pkg::DashYear:  year_acc_nxt  = dav_pkg::year_step(year_acc_r, digit);
        dav_pkg::DashMonth: month_acc_nxt = dav_pkg::sat_step(month_acc_r, digit);
        dav_pkg::DashDay:   day_acc_nxt   = dav_pkg::sat_step(day_acc_r, digit);
        default: ;
      endcase
    end else begin
      bad_char_nxt = 1'b1;
    end
  end

  assign ok = !bad_char_nxt && (dash_count_nxt == dav_pkg::DashDay) &&
              (month_acc_nxt >= dav_pkg::MonthMin) && (month_acc_nxt <= dav_pkg::MonthMax) &&
              (day_acc_nxt <= dav_pkg::day_limit(year_acc_nxt[1:0], month_acc_nxt));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && in_last_char) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dash_count_r <= 2'd0;
      bad_char_r   <= 1'b0;
      year_acc_r   <= '0;
      month_acc_r  <= '0;
      day_acc_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        if (in_last_char) begin
          dash_count_r <= 2'd0;
          bad_char_r   <= 1'b0;
          year_acc_r   <= '0;
          month_acc_r  <= '0;
          day_acc_r    <= '0;
        end else begin
          dash_count_r <= dash_count_nxt;
          bad_char_r   <= bad_char_nxt;
          year_acc_r   <= year_acc_nxt;
          month_acc_r  <= month_acc_nxt;
          day_acc_r    <= day_acc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last_char) begin
      date_ok_r <= ok;
      year_r    <= year_acc_nxt;
      month_r   <= month_acc_nxt;
      day_r     <= day_acc_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_date_ok     = date_ok_r;
  assign out_year_value  = year_r;
  assign out_month_value = month_r;
  assign out_day_value   = day_r;

endmodule

@@ hdl/dav_checker.sv @@
// Checker: port-level assertions for the date text validator, with bind
`include "date_text_validator_unit_defines.svh"

module dav_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_char,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_date_ok,
  input logic [15:0] out_year_value,
  input logic [7:0]  out_month_value,
  input logic [7:0]  out_day_value
);

  // a held result transaction keeps its payload
  `DAV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_date_ok, out_year_value, out_month_value, out_day_value}))

  // a valid date carries a month in range and a day within the longest month
  `DAV_ASSERT_NOW(a_ok_range, clk, rst_n, out_valid && out_date_ok, out_month_value >= dav_pkg::MonthMin && out_month_value <= dav_pkg::MonthMax && out_day_value <= dav_pkg::DayLong)

  // a non-final character produces no result
  `DAV_ASSERT_NEXT(a_no_spurious, clk, rst_n, in_valid && in_ready && !in_last_char, !out_valid)

  // reset leaves no result pending
  `DAV_ASSERT_RST(a_reset_idle, clk, !rst_n, !out_valid)

endmodule

bind date_text_validator_unit dav_checker u_dav_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_char    (in_last_char),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_date_ok     (out_date_ok),
  .out_year_value  (out_year_value),
  .out_month_value (out_month_value),
  .out_day_value   (out_day_value)
);
